### design/fcttl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fcttl_pkg;

  // Table geometry.
  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 64;

  // Request codes.
  localparam logic [2:0] REQ_CHECK  = 3'd0;
  localparam logic [2:0] REQ_GET    = 3'd1;
  localparam logic [2:0] REQ_PUT    = 3'd2;
  localparam logic [2:0] REQ_DELETE = 3'd3;
  localparam logic [2:0] REQ_PURGE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_DUP     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_CAP = 2'd0;
  localparam logic [1:0] REG_TTL = 2'd1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] key;
    logic [31:0] item_size;
    logic [31:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_size;
    logic [10:0] evicted_count;
    logic [47:0] used_bytes;
    logic [10:0] entry_total;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [KEY_W-1:0] key;
    logic [31:0] bytes;
    logic [31:0] stamp;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic       clr;
    logic       latch;
    logic       scan_init;
    logic       scan_newest;
    logic       scan_step;
    logic       grab;
    logic       set_status;
    logic [1:0] status_val;
    logic       set_found;
    logic       wr_get;
    logic       wr_put;
    logic       drop;
    logic       evict_inc;
    logic       calc;
    logic       load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       pv;
    logic       match;
    logic       valid_bit;
    logic       cnt_end;
    logic       clr_last;
    logic       expired;
    logic       over_cap;
    logic       over_purge;
    logic       count_zero;
  } sts_t;

endpackage
`default_nettype wire

### design/fcttl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module fcttl_dp (
  input  wire             clk,
  input  wire             rst_n,
  input  fcttl_pkg::cmd_t cmd,
  output fcttl_pkg::sts_t sts,
  input  fcttl_pkg::in_t  in_data,
  input  wire             cfg_we,
  input  wire [1:0]       cfg_index,
  input  wire [47:0]      cfg_wdata,
  output fcttl_pkg::out_t out_data
);
  import fcttl_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rdata_r;
  entry_t ent_r;
  entry_t mem_wdata;
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;

  logic [47:0] cap_r;
  logic [31:0] ttl_r;
  in_t         req_r;
  logic [IDX_W-1:0] ptr_r, ptr_nxt, rd_idx_r, hit_r, newest_r, newest_nxt;
  logic [CNT_W-1:0] cnt_r, count_r, evict_r;
  logic             pv_r;
  logic [48:0]      bytes_r;
  logic [51:0]      b5_r;
  logic [1:0]       status_r;
  logic [31:0]      found_r;
  out_t             out_r;
  logic [31:0]      age;

  // Ring increments with wrap.
  assign ptr_nxt    = (ptr_r == IDX_W'(ENTRIES - 1)) ? '0 : ptr_r + 1'b1;
  assign newest_nxt = (newest_r == IDX_W'(ENTRIES - 1)) ? '0 : newest_r + 1'b1;

  // Single write port shared by clearing, refresh, insert and removal.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ptr_r;
    mem_wdata = '0;
    if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.drop) begin
      mem_we   = 1'b1;
      mem_addr = hit_r;
    end else if (cmd.wr_get) begin
      mem_we    = 1'b1;
      mem_addr  = hit_r;
      mem_wdata = ent_r;
      mem_wdata.stamp = req_r.timestamp;
    end else if (cmd.wr_put) begin
      mem_we    = 1'b1;
      mem_addr  = newest_r;
      mem_wdata = {1'b1, req_r.key[KEY_W-1:0], req_r.item_size, req_r.timestamp};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r  <= mem[ptr_r];
    rd_idx_r <= ptr_r;
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= 48'd1099511627776;
      ttl_r    <= 32'd86400;
      ptr_r    <= '0;
      cnt_r    <= '0;
      pv_r     <= 1'b0;
      newest_r <= '0;
      bytes_r  <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_CAP) begin
        cap_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_TTL) begin
        ttl_r <= cfg_wdata[31:0];
      end
      pv_r <= cmd.scan_step;
      if (cmd.clr || cmd.scan_step) begin
        ptr_r <= ptr_nxt;
        cnt_r <= cnt_r + 1'b1;
      end else if (cmd.scan_init) begin
        ptr_r <= cmd.scan_newest ? newest_r : '0;
        cnt_r <= '0;
      end
      if (cmd.drop) begin
        bytes_r <= bytes_r - {17'd0, ent_r.bytes};
        count_r <= count_r - 1'b1;
      end else if (cmd.wr_put) begin
        bytes_r  <= bytes_r + {17'd0, req_r.item_size};
        count_r  <= count_r + 1'b1;
        newest_r <= newest_nxt;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r    <= in_data;
      status_r <= ST_OK;
      found_r  <= '0;
      evict_r  <= '0;
    end
    if (cmd.grab) begin
      ent_r <= rdata_r;
      hit_r <= rd_idx_r;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_val;
    end
    if (cmd.set_found) begin
      found_r <= ent_r.bytes;
    end
    if (cmd.evict_inc) begin
      evict_r <= evict_r + 1'b1;
    end
    if (cmd.calc) begin
      b5_r <= {bytes_r, 2'b00} + {3'd0, bytes_r};
    end
    if (cmd.load_out) begin
      out_r.status        <= status_r;
      out_r.found_size    <= found_r;
      out_r.evicted_count <= 11'(evict_r);
      out_r.used_bytes    <= bytes_r[48] ? '1 : bytes_r[47:0];
      out_r.entry_total   <= 11'(count_r);
    end
  end

  assign age = req_r.timestamp - ent_r.stamp;

  // Status towards the controller.
  always_comb begin
    sts.req_type   = req_r.req_type;
    sts.pv         = pv_r;
    sts.valid_bit  = rdata_r.valid;
    sts.match      = rdata_r.valid && (rdata_r.key == req_r.key[KEY_W-1:0]);
    sts.cnt_end    = (cnt_r == CNT_W'(ENTRIES));
    sts.clr_last   = (cnt_r == CNT_W'(ENTRIES - 1));
    sts.expired    = age > ttl_r;
    sts.over_cap   = bytes_r > {1'b0, cap_r};
    sts.over_purge = b5_r > {2'b00, cap_r, 2'b00};
    sts.count_zero = (count_r == '0);
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

### design/fcttl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fcttl_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  input  fcttl_pkg::sts_t sts,
  output fcttl_pkg::cmd_t cmd
);
  import fcttl_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ISSUE, S_LK, S_CK, S_GET, S_DEL,
    S_PN_INIT, S_PN_RD, S_PN_CHK, S_PN_DROP, S_PN_WR,
    S_EV_PRE, S_EV_CHK, S_EV_SCAN, S_EV_DROP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, ev_cond;

  assign out_free = !out_valid_r || !out_stall;
  assign ev_cond  = ((sts.req_type == REQ_PUT) ? sts.over_cap : sts.over_purge) &&
                    !sts.count_zero;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.scan_init = 1'b1;
        if (sts.req_type == REQ_PURGE) begin
          state_nxt = S_EV_PRE;
        end else if (sts.req_type == REQ_CHECK || sts.req_type == REQ_GET ||
                     sts.req_type == REQ_PUT || sts.req_type == REQ_DELETE) begin
          state_nxt = S_LK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // Key lookup: one read a cycle, compare on the registered data.
      S_LK: begin
        if (sts.pv && sts.match) begin
          cmd.grab = 1'b1;
          case (sts.req_type)
            REQ_CHECK:  state_nxt = S_CK;
            REQ_GET:    state_nxt = S_GET;
            REQ_DELETE: state_nxt = S_DEL;
            default: begin
              cmd.set_status = 1'b1;
              cmd.status_val = ST_DUP;
              state_nxt      = S_DONE;
            end
          endcase
        end else if (sts.cnt_end) begin
          if (sts.req_type == REQ_PUT) begin
            state_nxt = S_PN_INIT;
          end else begin
            cmd.set_status = 1'b1;
            cmd.status_val = ST_MISS;
            state_nxt      = S_DONE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CK: begin
        if (sts.expired) begin
          cmd.drop       = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_EXPIRED;
        end
        state_nxt = S_DONE;
      end
      S_GET: begin
        cmd.wr_get    = 1'b1;
        cmd.set_found = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DEL: begin
        cmd.drop      = 1'b1;
        cmd.set_found = 1'b1;
        state_nxt     = S_DONE;
      end
      // Insert: free the next ring slot if it is still occupied.
      S_PN_INIT: begin
        cmd.scan_init   = 1'b1;
        cmd.scan_newest = 1'b1;
        state_nxt       = S_PN_RD;
      end
      S_PN_RD: begin
        cmd.scan_step = 1'b1;
        state_nxt     = S_PN_CHK;
      end
      S_PN_CHK: begin
        if (sts.valid_bit) begin
          cmd.grab  = 1'b1;
          state_nxt = S_PN_DROP;
        end else begin
          state_nxt = S_PN_WR;
        end
      end
      S_PN_DROP: begin
        cmd.drop      = 1'b1;
        cmd.evict_inc = 1'b1;
        state_nxt     = S_PN_WR;
      end
      S_PN_WR: begin
        cmd.wr_put = 1'b1;
        state_nxt  = S_EV_PRE;
      end
      // Eviction loop: oldest entry is the first valid slot after the newest.
      S_EV_PRE: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EV_CHK;
      end
      S_EV_CHK: begin
        if (ev_cond) begin
          cmd.scan_init   = 1'b1;
          cmd.scan_newest = 1'b1;
          state_nxt       = S_EV_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_EV_SCAN: begin
        if (sts.pv && sts.valid_bit) begin
          cmd.grab  = 1'b1;
          state_nxt = S_EV_DROP;
        end else if (sts.cnt_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EV_DROP: begin
        cmd.drop      = 1'b1;
        cmd.evict_inc = 1'b1;
        state_nxt     = S_EV_PRE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### design/fifo_cache_ttl_byte_capacity.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Ports                          Direction  Beat
// in       in_valid, in_stall, in_data    input      one request
// out      out_valid, out_stall, out_data output     one result
// cfg      cfg_we, cfg_index, cfg_wdata   input      one register write
//
// After reset a clearing pass empties all ENTRIES (1024) slots before the first request.
// Most of the time of a request is the key lookup, which reads the table one entry a
// cycle through one read port. An insert that misses first frees its ring slot when it
// is occupied, and each eviction scans the table again for its oldest entry. A result
// stalled at the output holds the next request.
module fifo_cache_ttl_byte_capacity (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  fcttl_pkg::in_t  in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output fcttl_pkg::out_t out_data,
  input  wire             cfg_we,
  input  wire [1:0]       cfg_index,
  input  wire [47:0]      cfg_wdata
);
  import fcttl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcttl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcttl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### tb/fifo_cache_ttl_byte_capacity_tb.sv
`timescale 1ns / 1ps
module fifo_cache_ttl_byte_capacity_tb;
  import fcttl_pkg::*;

  // Request codes with no operation behind them.
  localparam logic [2:0] REQ_UNUSED_A = 3'd5;
  localparam logic [2:0] REQ_UNUSED_B = 3'd6;
  localparam logic [2:0] REQ_UNUSED_C = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_wdata;

  fifo_cache_ttl_byte_capacity u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the cache table and its registers.
  logic [63:0] sh_key   [ENTRIES];
  logic [31:0] sh_bytes [ENTRIES];
  logic [31:0] sh_stamp [ENTRIES];
  logic        sh_valid [ENTRIES];
  logic [9:0]  sh_newest;
  logic [9:0]  sh_oldest;
  logic [48:0] sh_held;
  logic [10:0] sh_count;
  logic [47:0] sh_cap;
  logic [31:0] sh_ttl;

  out_t        pending_results[$];
  int          errors;
  int          tx_idle_pct;
  int          rx_idle_pct;
  logic [31:0] tnow;
  logic [63:0] key_pool [12];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Compare every result beat with the oldest outstanding prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_data.status), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.found_size !== want.found_size)
          report_mismatch("found_size", 64'(out_data.found_size),
                          64'(want.found_size));
        if (out_data.evicted_count !== want.evicted_count)
          report_mismatch("evicted_count", 64'(out_data.evicted_count),
                          64'(want.evicted_count));
        if (out_data.used_bytes !== want.used_bytes)
          report_mismatch("used_bytes", 64'(out_data.used_bytes),
                          64'(want.used_bytes));
        if (out_data.entry_total !== want.entry_total)
          report_mismatch("entry_total", 64'(out_data.entry_total),
                          64'(want.entry_total));
      end
    end
  end

  // The oldest entry is the first valid one at or after the insertion point.
  function automatic void locate_oldest();
    logic [9:0] s;
    sh_oldest = sh_newest;
    for (int i = 0; i < ENTRIES; i++) begin
      s = sh_newest + i[9:0];
      if (sh_valid[s]) begin
        sh_oldest = s;
        return;
      end
    end
  endfunction

  function automatic void remove_slot(input logic [9:0] s);
    if (!sh_valid[s]) return;
    sh_valid[s] = 1'b0;
    sh_held = sh_held - {17'd0, sh_bytes[s]};
    sh_count = sh_count - 11'd1;
    locate_oldest();
  endfunction

  function automatic bit evict_one();
    if (sh_count == 0) return 1'b0;
    locate_oldest();
    remove_slot(sh_oldest);
    return 1'b1;
  endfunction

  function automatic int find_key(input logic [63:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (sh_valid[i] && sh_key[i] == k) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the expected result.
  function automatic out_t predict_cache(input in_t rq);
    out_t r;
    int   hit;
    logic [31:0] age;
    r = '0;
    case (rq.req_type)
      REQ_CHECK: begin
        hit = find_key(rq.key);
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          age = rq.timestamp - sh_stamp[hit];
          if (age > sh_ttl) begin
            remove_slot(hit[9:0]);
            r.status = ST_EXPIRED;
          end
        end
      end
      REQ_GET: begin
        hit = find_key(rq.key);
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          sh_stamp[hit] = rq.timestamp;
          r.found_size = sh_bytes[hit];
        end
      end
      REQ_PUT: begin
        if (find_key(rq.key) >= 0) begin
          r.status = ST_DUP;
        end else begin
          if (sh_valid[sh_newest]) begin
            remove_slot(sh_newest);
            r.evicted_count++;
          end
          sh_key[sh_newest]   = rq.key;
          sh_bytes[sh_newest] = rq.item_size;
          sh_stamp[sh_newest] = rq.timestamp;
          sh_valid[sh_newest] = 1'b1;
          sh_held  = sh_held + {17'd0, rq.item_size};
          sh_count = sh_count + 11'd1;
          sh_newest = sh_newest + 10'd1;
          locate_oldest();
          while (sh_held > {1'b0, sh_cap} && evict_one()) r.evicted_count++;
        end
      end
      REQ_DELETE: begin
        hit = find_key(rq.key);
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.found_size = sh_bytes[hit];
          remove_slot(hit[9:0]);
        end
      end
      REQ_PURGE: begin
        while ({3'd0, sh_held} * 52'd5 > {4'd0, sh_cap} * 52'd4 && evict_one())
          r.evicted_count++;
      end
      default: ;
    endcase
    r.used_bytes = sh_held[48] ? 48'hFFFF_FFFF_FFFF : sh_held[47:0];
    r.entry_total = sh_count;
    return r;
  endfunction

  // Drive one request beat, with an optional gap first, and wait for it to be taken.
  task automatic send_request(input logic [2:0] op, input logic [63:0] k,
                              input logic [31:0] sz, input logic [31:0] ts);
    in_t  rq;
    out_t exp_r;
    rq = '{req_type: op, key: k, item_size: sz, timestamp: ts};
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    exp_r = predict_cache(rq);
    pending_results = {pending_results, exp_r};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_CAP) sh_cap = val;
    else if (idx == REG_TTL) sh_ttl = val[31:0];
    @(posedge clk);
  endtask

  // Directed cases: hits, misses, expiry across the timestamp wrap, duplicates,
  // oversized inserts, purge and unused request codes.
  task automatic test_directed();
    send_request(REQ_GET, 64'd5, 32'd0, 32'd0);
    send_request(REQ_PUT, 64'd5, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_request(REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'd0);
    send_request(REQ_PUT, 64'd0, 32'd77, 32'h1000);
    send_request(REQ_PUT, 64'd5, 32'd9, 32'h1000);
    send_request(REQ_CHECK, 64'd5, 32'hFFFF_FFFF, 32'h0001_0000);
    send_request(REQ_GET, 64'd5, 32'd0, 32'h0000_0010);
    send_request(REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_DELETE, 64'd1234, 32'd0, 32'd0);
    send_request(REQ_DELETE, 64'd0, 32'd0, 32'd0);
    send_request(REQ_UNUSED_A, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED_B, 64'd0, 32'd0, 32'd0);
    send_request(REQ_UNUSED_C, 64'd1, 32'd1, 32'd1);
    // Sender holds off until every result is in.
    wait_drained();
    write_reg(REG_TTL, 48'hABCD_0000_0020);
    // Entry stamped at the top of the range, checked just after the wrap.
    send_request(REQ_PUT, 64'd9, 32'd3, 32'hFFFF_FFF0);
    send_request(REQ_CHECK, 64'd9, 32'd0, 32'h0000_0010);
    send_request(REQ_CHECK, 64'd9, 32'd0, 32'h0000_0011);
    send_request(REQ_CHECK, 64'd5, 32'd0, 32'h0000_0030);
    wait_drained();
    write_reg(REG_CAP, 48'd1000);
    send_request(REQ_PUT, 64'd20, 32'd500, 32'd0);
    send_request(REQ_PUT, 64'd21, 32'd400, 32'd0);
    send_request(REQ_PURGE, 64'd0, 32'd0, 32'd0);
    send_request(REQ_PUT, 64'd22, 32'd5000, 32'd0);
    send_request(REQ_PURGE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
  endtask

  // Wrap the ring so that the next insert lands on an occupied slot, then
  // again after a hole has been punched by a delete.
  task automatic test_ring_wrap();
    write_reg(REG_CAP, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < ENTRIES; i++)
      send_request(REQ_PUT, 64'h1_0000 + 64'(i), $urandom_range(0, 1000), tnow);
    send_request(REQ_PUT, 64'h2_0000, 32'd1, tnow);
    send_request(REQ_DELETE, 64'h1_0200, 32'd0, tnow);
    send_request(REQ_PUT, 64'h2_0001, 32'd2, tnow);
    wait_drained();
    write_reg(REG_CAP, 48'd0);
    send_request(REQ_PURGE, 64'd0, 32'd0, 32'd0);
    wait_drained();
  endtask

  // Random traffic over a small key pool so that hits and evictions are common.
  task automatic test_random(input int n, input int step, input int size_max);
    logic [2:0]  op;
    logic [63:0] k;
    logic [31:0] sz;
    logic [31:0] ts;
    int          w;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(99);
      if (w < 35) op = REQ_PUT;
      else if (w < 55) op = REQ_GET;
      else if (w < 75) op = REQ_CHECK;
      else if (w < 87) op = REQ_DELETE;
      else if (w < 95) op = REQ_PURGE;
      else op = 3'($urandom_range(REQ_UNUSED_A, REQ_UNUSED_C));
      if ($urandom_range(9) == 0) k = {$urandom, $urandom};
      else k = key_pool[$urandom_range(11)];
      w = $urandom_range(19);
      if (w == 0) sz = 32'hFFFF_FFFF;
      else if (w == 1) sz = $urandom;
      else sz = $urandom_range(0, size_max);
      tnow = tnow + $urandom_range(0, step);
      ts = ($urandom_range(19) == 0) ? $urandom : tnow;
      send_request(op, k, sz, ts);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CAP;
    cfg_wdata = '0;
    out_stall = 1'b0;
    errors = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    tnow = 32'd1000;
    sh_newest = '0;
    sh_oldest = '0;
    sh_held = '0;
    sh_count = '0;
    sh_cap = 48'd1 << 40;
    sh_ttl = 32'd86400;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_bytes[i] = '0;
      sh_stamp[i] = '0;
    end
    key_pool[0] = 64'd0;
    key_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[2] = 64'h8000_0000_0000_0000;
    for (int i = 3; i < 12; i++) key_pool[i] = {$urandom, $urandom};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 84;
    test_directed();
    test_ring_wrap();
    write_reg(REG_CAP, 48'd2000);
    write_reg(REG_TTL, 48'd100);
    test_random(300, 60, 400);

    tx_idle_pct = 84;
    rx_idle_pct = 38;
    write_reg(REG_CAP, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_TTL, 48'd0);
    test_random(300, 2, 100000);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_CAP, 48'd0);
    write_reg(REG_TTL, 48'hFFFF_FFFF);
    test_random(125, 1000, 50);
    write_reg(REG_CAP, 48'd5000);
    write_reg(REG_TTL, 48'd300);
    test_random(125, 100, 900);

    repeat (2100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #500_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
